// ===== rtl/swm_pkg.sv =====
// shared types and constants of the sliding window median filter
// no dependencies; used by swm_cell and sliding_window_median
package swm_pkg;

   localparam int MAX_WINDOW  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
   localparam int AGE_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int IDX_BITS    = AGE_BITS;
   localparam int OUT_BITS    = SAMPLE_BITS + 1;
   localparam int REQ_BYTES   = (SAMPLE_BITS + 7) / 8;
   localparam int RSP_BYTES   = (OUT_BITS + 7) / 8;
   localparam int CSR_BITS    = 6;

   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [AGE_BITS-1:0]           age;
   } entry_type;

   // what a cell shows its neighbors
   typedef struct packed {
      entry_type ent;
      logic      le;   // valid and value <= incoming sample
      logic      sh;   // the removed entry sits at or below this cell
   } link_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic                          advance;
      logic                          flush;
      logic                          full;
      logic [AGE_BITS-1:0]           oldest_age;
      logic signed [SAMPLE_BITS-1:0] sample;
   } cell_ctl_type;

endpackage

// ===== rtl/swm_cell.sv =====
// one slot of the sorted window: value, age and valid flag
// depends on swm_pkg
module swm_cell
   import swm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  link_type     left_link,
   input  link_type     right_link,
   output link_type     link,
   output entry_type    entry
);

   entry_type ent_ff, ent_in;
   entry_type cur_ent, prev_ent, new_ent, pick;
   logic      old_hit, le_own, le_cur, le_prev;

   always_comb begin
      old_hit = ctl.full && ent_ff.valid && (ent_ff.age == ctl.oldest_age);
      le_own  = ent_ff.valid && (ent_ff.value <= ctl.sample);

      link.ent = ent_ff;
      link.le  = le_own;
      link.sh  = left_link.sh | old_hit;

      // slot content once the oldest entry has left
      cur_ent  = link.sh ? right_link.ent : ent_ff;
      le_cur   = link.sh ? right_link.le : le_own;
      prev_ent = left_link.sh ? ent_ff : left_link.ent;
      le_prev  = left_link.sh ? le_own : left_link.le;

      new_ent.valid = 1'b1;
      new_ent.value = ctl.sample;
      new_ent.age   = '0;

      priority if (le_cur) begin
         pick = cur_ent;
      end else if (le_prev) begin
         pick = new_ent;
      end else begin
         pick = prev_ent;
      end
      // everything already in the window grows one older
      if (!(le_prev && !le_cur)) begin
         pick.age = pick.age + AGE_BITS'(1);
      end

      ent_in = ent_ff;
      if (ctl.flush) begin
         ent_in.valid = 1'b0;
      end else if (ctl.advance) begin
         ent_in = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.value <= ent_in.value;
      ent_ff.age   <= ent_in.age;
   end

   assign entry = ent_ff;

endmodule

// ===== rtl/sliding_window_median.sv =====
// top level of the sliding window median filter: cell chain, fill count, output stage
// depends on swm_pkg and swm_cell
//
// Sliding window median filter. Signed 16-bit samples enter on req_*; the last
// window_len samples are kept in a chain of MAX_WINDOW cells that stays sorted
// in ascending order, each cell carrying the age of its sample. A sample is
// taken every clock: in the cycle of the transfer the oldest sample leaves (once
// the window is full) and the new one is put in its place in the order, all
// cells moving at once. The output register takes twice the median (sum of the
// two middle values, or twice the middle value for an odd length), shown on rsp_*
// as 17-bit two's complement with one fractional bit. No result comes until the
// window has filled. Writing window_len on csr_* empties the window; a length of
// zero behaves as one and a length above 32 as 32. The only stall source is the
// output register: req_tready drops while a finished result waits behind one
// that rsp_tready has not taken.
module sliding_window_median
   import swm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_BYTES*8-1:0] req_tdata,   // [15:0] sample
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_BYTES*8-1:0] rsp_tdata,   // [16:0] median_x2
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_BITS-1:0]    csr_wr_data  // window_len
);

   // registers
   logic [CSR_BITS-1:0]        len_ff, len_in;
   logic [LEN_BITS-1:0]        fill_ff, fill_in;
   logic                       pend_ff, pend_in;
   logic                       out_vld_ff, out_vld_in;
   logic signed [OUT_BITS-1:0] out_ff, out_in;

   // control
   logic [LEN_BITS-1:0]        eff_len, fill_next;
   logic                       full, accept, out_stall, load_out;
   logic [IDX_BITS-1:0]        hi_idx, lo_idx;
   logic signed [SAMPLE_BITS-1:0] hi_val, lo_val;
   cell_ctl_type               ctl;

   link_type  links [MAX_WINDOW];
   entry_type ents  [MAX_WINDOW];
   link_type  edge_left, edge_right;

   // effective window length: zero acts as one, too large clips
   always_comb begin
      if (csr_wr_data == '0) begin
         len_in = csr_wr_data;
      end else begin
         len_in = csr_wr_data;
      end
      if (len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (32'(len_ff) > MAX_WINDOW) begin
         eff_len = LEN_BITS'(MAX_WINDOW);
      end else begin
         eff_len = LEN_BITS'(len_ff);
      end
   end

   // handshake: hold the chain while a result waits behind a stalled output
   assign out_stall  = out_vld_ff && !rsp_tready;
   assign req_tready = !(pend_ff && out_stall);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = pend_ff && !out_stall;

   assign full      = (fill_ff == eff_len);
   assign fill_next = full ? fill_ff : fill_ff + LEN_BITS'(1);

   always_comb begin
      ctl.advance    = accept;
      ctl.flush      = csr_wr_en;
      ctl.full       = full;
      ctl.oldest_age = AGE_BITS'(eff_len - LEN_BITS'(1));
      ctl.sample     = req_tdata[SAMPLE_BITS-1:0];

      // chain ends: below the first cell everything counts as smaller,
      // above the last there is nothing
      edge_left.ent   = '0;
      edge_left.le    = 1'b1;
      edge_left.sh    = 1'b0;
      edge_right.ent  = '0;
      edge_right.le   = 1'b0;
      edge_right.sh   = 1'b0;

      fill_in = fill_ff;
      pend_in = pend_ff && !load_out;
      if (csr_wr_en) begin
         fill_in = '0;
         pend_in = 1'b0;
      end else if (accept) begin
         fill_in = fill_next;
         pend_in = (fill_next == eff_len);
      end
   end

   // the sorted chain
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_link  ((k == 0) ? edge_left : links[(k == 0) ? 0 : k-1]),
         .right_link ((k == MAX_WINDOW-1) ? edge_right
                                          : links[(k == MAX_WINDOW-1) ? k : k+1]),
         .link       (links[k]),
         .entry      (ents[k])
      );
   end

   // middle taps, picked one-hot from the settled chain
   always_comb begin
      logic [LEN_BITS-1:0] half;
      half   = eff_len >> 1;
      hi_idx = IDX_BITS'(half);
      lo_idx = eff_len[0] ? IDX_BITS'(half) : IDX_BITS'(half - LEN_BITS'(1));
      hi_val = '0;
      lo_val = '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (IDX_BITS'(k) == hi_idx) begin
            hi_val = hi_val | ents[k].value;
         end
         if (IDX_BITS'(k) == lo_idx) begin
            lo_val = lo_val | ents[k].value;
         end
      end
   end

   // output register
   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      if (load_out) begin
         out_in     = OUT_BITS'(hi_val) + OUT_BITS'(lo_val);
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= CSR_BITS'(3);
         fill_ff    <= '0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= len_in;
         end
         fill_ff    <= fill_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_BYTES*8-OUT_BITS){1'b0}}, out_ff};

endmodule
